// ===== hw/rtl/esc_pkg.sv =====
// ============================================================================
// esc_pkg
// Shared types for the elevator scan controller: car modes, step operations
// and the command and status groups between the controller and the datapath.
// ============================================================================
`default_nettype none

package esc_pkg;

    localparam int FLOOR_W = 8;

    typedef logic [FLOOR_W-1:0] floor_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } mode_t;

    // Work selected for one item when it is accepted
    typedef enum logic [2:0] {
        OP_REQUEST = 3'd0,
        OP_IDLE    = 3'd1,
        OP_UP      = 3'd2,
        OP_DOWN    = 3'd3,
        OP_NONE    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_WAIT   = 3'd0,
        ST_STEP   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_FINISH = 3'd3,
        ST_LOAD   = 3'd4
    } state_t;

    typedef struct packed {
        logic capture;   // latch the accepted item
        logic step;      // move the car, seed the accumulators
        logic scan;      // process the head slot and rotate the ring
        logic finish;    // commit targets and mode
        logic load_out;  // copy the result into the output register
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/esc_slot_ring.sv =====
// ============================================================================
// esc_slot_ring
// Rider slot storage arranged as a rotating ring; the datapath sees and
// rewrites only the head slot, one slot per cycle while shift is high.
// ============================================================================
`default_nettype none

module esc_slot_ring #(
    parameter int RIDER_SLOTS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire esc_pkg::floor_t new_entry,
    input  wire esc_pkg::floor_t new_exit,
    input  wire logic            new_inside,
    output esc_pkg::floor_t      head_entry,
    output esc_pkg::floor_t      head_exit,
    output logic                 head_inside
);

    esc_pkg::floor_t entry_reg  [RIDER_SLOTS];
    esc_pkg::floor_t exit_reg   [RIDER_SLOTS];
    logic            inside_reg [RIDER_SLOTS];

    genvar i;
    generate
        for (i = 0; i < RIDER_SLOTS; i++) begin : g_slot
            // Advance each slot toward the head; the rewritten head enters at the tail
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    entry_reg[i]  <= '0;
                    exit_reg[i]   <= '0;
                    inside_reg[i] <= 1'b0;
                end
                else if (shift)
                begin
                    if (i == RIDER_SLOTS - 1)
                    begin
                        entry_reg[i]  <= new_entry;
                        exit_reg[i]   <= new_exit;
                        inside_reg[i] <= new_inside;
                    end
                    else
                    begin
                        entry_reg[i]  <= entry_reg[(i + 1) % RIDER_SLOTS];
                        exit_reg[i]   <= exit_reg[(i + 1) % RIDER_SLOTS];
                        inside_reg[i] <= inside_reg[(i + 1) % RIDER_SLOTS];
                    end
                end
            end
        end
    endgenerate

    assign head_entry  = entry_reg[0];
    assign head_exit   = exit_reg[0];
    assign head_inside = inside_reg[0];

endmodule

`default_nettype wire

// ===== hw/rtl/esc_datapath.sv =====
// ============================================================================
// esc_datapath
// Car state, target accumulators, per-slot update logic and output register.
// ============================================================================
`default_nettype none

module esc_datapath #(
    parameter int RIDER_SLOTS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire esc_pkg::cmd_t   cmd,
    input  wire logic            action,
    input  wire esc_pkg::floor_t request_entry_floor,
    input  wire esc_pkg::floor_t request_exit_floor,
    output esc_pkg::floor_t      car_floor,
    output logic [1:0]           car_mode,
    output esc_pkg::floor_t      upper_target,
    output esc_pkg::floor_t      lower_target,
    output logic                 request_rejected
);

    esc_pkg::floor_t floor_reg, floor_next;
    esc_pkg::floor_t max_reg, max_next;
    esc_pkg::floor_t min_reg, min_next;
    esc_pkg::mode_t  mode_reg, mode_next;
    esc_pkg::op_t    op_reg, op_next;
    esc_pkg::floor_t req_entry_reg, req_entry_next;
    esc_pkg::floor_t req_exit_reg, req_exit_next;
    esc_pkg::floor_t acc_max_reg, acc_max_next;
    esc_pkg::floor_t acc_min_reg, acc_min_next;
    logic            found_reg, found_next;
    logic            rejected_reg, rejected_next;

    esc_pkg::floor_t out_floor_reg, out_max_reg, out_min_reg;
    logic [1:0]      out_mode_reg;
    logic            out_rej_reg;

    esc_pkg::floor_t head_entry, head_exit;
    logic            head_inside;
    esc_pkg::floor_t new_entry, new_exit;
    logic            new_inside;

    esc_slot_ring #(
        .RIDER_SLOTS(RIDER_SLOTS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (cmd.scan),
        .new_entry  (new_entry),
        .new_exit   (new_exit),
        .new_inside (new_inside),
        .head_entry (head_entry),
        .head_exit  (head_exit),
        .head_inside(head_inside)
    );

    always_comb
    begin
        esc_pkg::floor_t e1;
        esc_pkg::floor_t x1;
        logic            in1;
        logic            in2;
        esc_pkg::floor_t amax;
        esc_pkg::floor_t amin;
        esc_pkg::floor_t peak;
        esc_pkg::floor_t low;

        floor_next     = floor_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        mode_next      = mode_reg;
        op_next        = op_reg;
        req_entry_next = req_entry_reg;
        req_exit_next  = req_exit_reg;
        acc_max_next   = acc_max_reg;
        acc_min_next   = acc_min_reg;
        found_next     = found_reg;
        rejected_next  = rejected_reg;
        new_entry      = head_entry;
        new_exit       = head_exit;
        new_inside     = head_inside;
        e1             = head_entry;
        x1             = head_exit;
        in1            = head_inside;
        in2            = head_inside;
        amax           = acc_max_reg;
        amin           = acc_min_reg;
        peak           = max_reg;
        low            = min_reg;

        // Latch the item and decide which step it runs
        if (cmd.capture)
        begin
            req_entry_next = request_entry_floor;
            req_exit_next  = request_exit_floor;
            if (action)
                op_next = esc_pkg::OP_REQUEST;
            else
            begin
                unique case (mode_reg)
                    esc_pkg::MODE_IDLE: op_next = esc_pkg::OP_IDLE;
                    esc_pkg::MODE_UP:   op_next = esc_pkg::OP_UP;
                    esc_pkg::MODE_DOWN: op_next = esc_pkg::OP_DOWN;
                    default:            op_next = esc_pkg::OP_NONE;
                endcase
            end
        end

        // Move the car by at most one floor and seed the accumulators
        if (cmd.step)
        begin
            found_next = 1'b0;
            if (op_reg == esc_pkg::OP_UP && floor_reg < max_reg)
                floor_next = floor_reg + 8'd1;
            else if (op_reg == esc_pkg::OP_DOWN && floor_reg > min_reg)
                floor_next = floor_reg - 8'd1;
            acc_max_next = (op_reg == esc_pkg::OP_IDLE) ? floor_next : '0;
            acc_min_next = floor_next;
        end

        // Head slot: store, board, drop off and track extremes
        if (cmd.scan)
        begin
            unique case (op_reg)
                esc_pkg::OP_REQUEST:
                begin
                    if (!found_reg && head_entry == '0 && head_exit == '0)
                    begin
                        new_entry  = req_entry_reg;
                        new_exit   = req_exit_reg;
                        found_next = 1'b1;
                    end
                end
                esc_pkg::OP_IDLE:
                begin
                    if (head_entry > amax)
                        amax = head_entry;
                    if (head_entry < amin && head_entry != '0)
                        amin = head_entry;
                    if (head_entry == floor_reg)
                    begin
                        e1  = '0;
                        in1 = 1'b1;
                    end
                    in2 = in1;
                    if (e1 == floor_reg)
                    begin
                        x1  = '0;
                        in2 = 1'b0;
                    end
                    new_entry    = e1;
                    new_exit     = x1;
                    new_inside   = in2;
                    acc_max_next = amax;
                    acc_min_next = amin;
                end
                esc_pkg::OP_UP, esc_pkg::OP_DOWN:
                begin
                    if (head_entry == floor_reg && !head_inside)
                    begin
                        e1  = '0;
                        in1 = 1'b1;
                    end
                    in2 = in1;
                    if (head_exit == floor_reg && in1)
                    begin
                        x1  = '0;
                        in2 = 1'b0;
                    end
                    if (e1 > amax && !in2)
                        amax = e1;
                    if (x1 > amax && in2)
                        amax = x1;
                    if (e1 < amin && !in2 && e1 != '0)
                        amin = e1;
                    if (x1 < amin && in2 && x1 != '0)
                        amin = x1;
                    new_entry    = e1;
                    new_exit     = x1;
                    new_inside   = in2;
                    acc_max_next = amax;
                    acc_min_next = amin;
                end
                default:
                begin
                end
            endcase
        end

        // Set the reject flag for a request; else commit targets, then start, reverse, continue or go idle
        if (cmd.finish)
        begin
            rejected_next = 1'b0;
            unique case (op_reg)
                esc_pkg::OP_REQUEST:
                    rejected_next = !found_reg;
                esc_pkg::OP_IDLE:
                begin
                    max_next = acc_max_reg;
                    min_next = acc_min_reg;
                    if (acc_max_reg != '0 && acc_max_reg > floor_reg)
                        mode_next = esc_pkg::MODE_UP;
                    else if (acc_min_reg != '0 && acc_min_reg < floor_reg)
                        mode_next = esc_pkg::MODE_DOWN;
                end
                esc_pkg::OP_UP:
                begin
                    peak     = (acc_max_reg > max_reg) ? acc_max_reg : max_reg;
                    max_next = acc_max_reg;
                    min_next = acc_min_reg;
                    if (floor_reg == peak)
                    begin
                        max_next  = floor_reg;
                        mode_next = (acc_min_reg < floor_reg) ? esc_pkg::MODE_DOWN
                                                              : esc_pkg::MODE_IDLE;
                    end
                end
                esc_pkg::OP_DOWN:
                begin
                    low      = (acc_min_reg < min_reg) ? acc_min_reg : min_reg;
                    max_next = acc_max_reg;
                    min_next = acc_min_reg;
                    if (floor_reg == low)
                    begin
                        min_next = floor_reg;
                        if (acc_max_reg > floor_reg)
                            mode_next = esc_pkg::MODE_UP;
                        else
                        begin
                            max_next  = floor_reg;
                            mode_next = esc_pkg::MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= 8'd1;
            max_reg   <= '0;
            min_reg   <= '0;
            mode_reg  <= esc_pkg::MODE_IDLE;
            op_reg    <= esc_pkg::OP_NONE;
        end
        else
        begin
            floor_reg <= floor_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            mode_reg  <= mode_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_entry_reg <= req_entry_next;
        req_exit_reg  <= req_exit_next;
        acc_max_reg   <= acc_max_next;
        acc_min_reg   <= acc_min_next;
        found_reg     <= found_next;
        rejected_reg  <= rejected_next;
        if (cmd.load_out)
        begin
            out_floor_reg <= floor_reg;
            out_mode_reg  <= mode_reg;
            out_max_reg   <= max_reg;
            out_min_reg   <= min_reg;
            out_rej_reg   <= rejected_reg;
        end
    end

    assign car_floor        = out_floor_reg;
    assign car_mode         = out_mode_reg;
    assign upper_target     = out_max_reg;
    assign lower_target     = out_min_reg;
    assign request_rejected = out_rej_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/esc_ctrl.sv =====
// ============================================================================
// esc_ctrl
// Sequencer for one item: accept, step, slot sweep, commit, result hand-off.
// ============================================================================
`default_nettype none

module esc_ctrl #(
    parameter int RIDER_SLOTS = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output esc_pkg::cmd_t cmd
);

    localparam int CW = (RIDER_SLOTS > 1) ? $clog2(RIDER_SLOTS) : 1;
    localparam logic [CW-1:0] LAST = CW'(RIDER_SLOTS - 1);
    localparam logic [CW-1:0] ONE  = CW'(1);

    esc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esc_pkg::ST_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            esc_pkg::ST_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = esc_pkg::ST_STEP;
                end
            end
            esc_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                cnt_next   = '0;
                state_next = esc_pkg::ST_SCAN;
            end
            esc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + ONE;
                if (cnt_reg == LAST)
                    state_next = esc_pkg::ST_FINISH;
            end
            esc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = esc_pkg::ST_LOAD;
            end
            esc_pkg::ST_LOAD:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = esc_pkg::ST_WAIT;
                end
            end
            default:
                state_next = esc_pkg::ST_WAIT;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/elevator_scan_controller.sv =====
// A new item is taken only once the last one is in the output register; the
// slot sweep walks the rider ring one slot per cycle, and every item (request
// or tick) makes one lap.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; car at floor 1, idle, targets zero, all
// rider slots cleared at once.
// ============================================================================
// elevator_scan_controller
// Single-car SCAN scheduler: a controller sequences each item while the
// datapath holds the car state and a rotating ring of rider slots.
// ============================================================================
`default_nettype none

module elevator_scan_controller #(
    parameter int RIDER_SLOTS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [7:0] request_entry_floor,
    input  wire logic [7:0] request_exit_floor,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      car_floor,
    output logic [1:0]      car_mode,
    output logic [7:0]      upper_target,
    output logic [7:0]      lower_target,
    output logic            request_rejected
);

    // Commands from the sequencer to the datapath
    esc_pkg::cmd_t cmd;

    // Sequencer: accepts one item, steps the car, sweeps the ring once,
    // commits the new targets and mode, then hands the result off.
    esc_ctrl #(
        .RIDER_SLOTS(RIDER_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    // Datapath: car floor, mode and targets, rider slots and the result
    // register that drives the output payload.
    esc_datapath #(
        .RIDER_SLOTS(RIDER_SLOTS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .action             (action),
        .request_entry_floor(request_entry_floor),
        .request_exit_floor (request_exit_floor),
        .car_floor          (car_floor),
        .car_mode           (car_mode),
        .upper_target       (upper_target),
        .lower_target       (lower_target),
        .request_rejected   (request_rejected)
    );

endmodule

`default_nettype wire
